### rtl/core/sbdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdm_pkg: shared types and constants
// widths and the cell record of the sorting chain
// ----------------------------------------------------------------------------
package sbdm_pkg;
  localparam int MaxElements = 64;
  localparam int CntW = $clog2(MaxElements + 1);
  localparam int IdxW = $clog2(MaxElements);
  localparam int ValW = 16;
  localparam int SumW = 23;
  localparam int NumW = 24;
  localparam int KeyW = 24;

  typedef struct packed {
    logic            vld;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] val;
  } cell_t;
endpackage

### rtl/core/sort_by_distance_to_mean_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_by_distance_to_mean_top: sort a set by distance to its mean
// loads values until last, then emits them ordered by |(v*n-s)/n|, then value
// ----------------------------------------------------------------------------
// channel  dir  tdata                 tuser  tlast
// s_axis   in   [15:0] sample_value   -      last_item
// m_axis   out  [15:0] sorted_value   -      last_out
// loading takes one item per cycle; after last each element passes through
// store read, product, 24-step serial key divide and chain insertion, then
// the chain settles before the sorted set is emitted. the serial divider
// dominates the sorting time. asynchronous active-low reset empties the
// block; no input is taken while sorting or emitting, output stalls hold.
module sort_by_distance_to_mean_top import sbdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // sample_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // sorted_value
  output logic        m_axis_tlast
);
  typedef enum logic [2:0] {LOAD, RD, MUL, DIV, INS, SETTLE, EMIT} state_e;
  state_e state_q;
  logic [ValW-1:0] mem [MaxElements];
  logic [ValW-1:0] rd_q;
  logic [CntW-1:0] cnt_q, idx_q, out_q;
  logic signed [SumW-1:0] sum_q;
  logic [NumW-1:0] num_abs;
  logic div_start, div_done, clr, shift, ins;
  logic chain_busy;
  logic [KeyW-1:0] quo;
  cell_t cin [MaxElements];
  cell_t held [MaxElements];
  cell_t pass [MaxElements];
  logic signed [SumW+CntW:0] prod;
  logic s_acc, m_acc;

  assign s_axis_tready = (state_q == LOAD);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == EMIT);
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = held[0].val;
  assign m_axis_tlast = (out_q == cnt_q - 1'b1);
  assign div_start = (state_q == MUL);
  assign clr = (state_q == LOAD) && s_acc && s_axis_tlast && 1'b0;
  assign shift = m_acc;
  assign prod = $signed(rd_q) * $signed({1'b0, cnt_q}) - sum_q;
  assign num_abs = prod[SumW+CntW] ? NumW'(-prod) : NumW'(prod);

  always_comb begin
    chain_busy = 1'b0;
    for (int i = 0; i < MaxElements; i++) chain_busy = chain_busy | pass[i].vld;
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && cnt_q < CntW'(MaxElements)) mem[cnt_q[IdxW-1:0]] <= s_axis_tdata;
    rd_q <= mem[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LOAD;
      cnt_q <= '0;
      sum_q <= '0;
      idx_q <= '0;
      out_q <= '0;
    end else begin
      case (state_q)
        LOAD: if (s_acc) begin
          if (cnt_q < CntW'(MaxElements)) begin
            cnt_q <= cnt_q + 1'b1;
            sum_q <= sum_q + SumW'($signed(s_axis_tdata));
          end
          idx_q <= '0;
          if (s_axis_tlast) begin
            if (cnt_q == '0 && 1'b0) state_q <= LOAD;
            else state_q <= RD;
          end
        end
        RD: state_q <= MUL;
        MUL: state_q <= DIV;
        DIV: if (div_done) state_q <= INS;
        INS: begin
          if (idx_q + 1'b1 == cnt_q) begin
            state_q <= SETTLE;
            out_q <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= RD;
          end
        end
        SETTLE: if (!chain_busy) state_q <= EMIT;
        EMIT: if (m_acc) begin
          if (out_q == cnt_q - 1'b1) begin
            state_q <= LOAD;
            cnt_q <= '0;
            sum_q <= '0;
          end
          out_q <= out_q + 1'b1;
        end
        default: state_q <= LOAD;
      endcase
    end
  end

  assign ins = (state_q == INS);

  sbdm_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(num_abs),
    .den_i(cnt_q), .done_o(div_done), .quo_o(quo)
  );

  for (genvar g = 0; g < MaxElements; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cin[g] = ins ? cell_t'{1'b1, quo, rd_q} : '0;
    end else begin : g_body
      assign cin[g] = pass[g-1];
    end
    sbdm_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .clr_i(clr), .shift_i(shift),
      .in_i(shift ? cell_t'('0) : cin[g]),
      .nb_i((g == MaxElements - 1) ? cell_t'('0) : held[(g+1) % MaxElements]),
      .held_o(held[g]), .pass_o(pass[g])
    );
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> held[0].vld) else $error("emit from empty cell");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("held data moved");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("load during emit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxElements)) else $error("count overflow");
endmodule

### rtl/core/sbdm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdm_div: iterative key divider
// restoring divide of |v*n - s| by n, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sbdm_div import sbdm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [CntW-1:0] den_i,
  output logic            done_o,
  output logic [KeyW-1:0] quo_o
);
  localparam int StepW = $clog2(NumW + 1);
  logic [NumW-1:0]  quo_q, quo_d;
  logic [CntW:0]    rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [CntW:0]    trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      step_d = StepW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[CntW-1:0], quo_q[NumW-1]};
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

### rtl/core/sbdm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdm_cell: insertion chain cell; clear empties it, shift loads nb_i
// else keeps the smaller of held and incoming entry, registers other onward
// ----------------------------------------------------------------------------
module sbdm_cell import sbdm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  clr_i,
  input  logic  shift_i,
  input  cell_t in_i,
  input  cell_t nb_i,
  output cell_t held_o,
  output cell_t pass_o
);
  cell_t held_q, held_d;
  cell_t pass_q, pass_d;
  logic  in_less;

  always_comb begin
    in_less = in_i.vld && (!held_q.vld || (in_i.key < held_q.key) ||
              (in_i.key == held_q.key && $signed(in_i.val) < $signed(held_q.val)));
    held_d = held_q;
    pass_d = '0;
    if (clr_i) held_d = '0;
    else if (shift_i) held_d = nb_i;
    else if (in_i.vld) begin
      if (in_less) begin
        held_d = in_i;
        pass_d = held_q;
      end else begin
        pass_d = in_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign held_o = held_q;
  assign pass_o = pass_q;
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for sort_by_distance_to_mean_top
// loads sets of signed values over the input stream and checks that each set
// comes back ordered by the truncated distance to its mean, ties by value
// ----------------------------------------------------------------------------
module tb_top;
  import sbdm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // sample_value
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // sorted_value
  logic        m_axis_tlast;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } sorted_item_t;

  typedef struct {
    logic [15:0] value;
    logic        last;
    logic        has_exp;
    logic [15:0] exp_value;
  } stim_row_t;

  sort_by_distance_to_mean_top uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic signed [15:0] held_vals[$];
  logic signed [22:0] held_sum;
  sorted_item_t       sorted_expect_q[$];
  int                 mismatch_cnt;
  int                 hold_off_cycles;
  logic               sink_stalled;
  logic [15:0]        last_seen;

  function automatic longint dist_of(logic signed [15:0] v, int n, longint s);
    longint q;
    q = (longint'(v) * n - s) / n;
    return q < 0 ? -q : q;
  endfunction

  task automatic take_sample(logic [15:0] v, logic lst);
    longint keys[$];
    logic signed [15:0] vals[$];
    longint k;
    int n;
    int j;
    sorted_item_t it;
    if (held_vals.size() < MaxElements) begin
      held_vals.push_back(v);
      held_sum = held_sum + 23'(signed'(v));
    end
    if (lst) begin
      n = held_vals.size();
      for (int i = 0; i < n; i++) begin
        k = dist_of(held_vals[i], n, longint'(held_sum));
        j = 0;
        while (j < keys.size() && (keys[j] < k || (keys[j] == k && vals[j] <= held_vals[i])))
          j++;
        keys.insert(j, k);
        vals.insert(j, held_vals[i]);
      end
      for (int i = 0; i < n; i++) begin
        it.value = vals[i];
        it.last = (i == n - 1);
        sorted_expect_q.push_back(it);
      end
      held_vals.delete();
      held_sum = '0;
    end
  endtask

  // leaves tvalid up at the falling edge after the accept; the next item
  // replaces it or takes it down for a gap, and a drain takes it down
  task automatic send_sample(logic [15:0] v, logic lst);
    int gap;
    gap = $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tlast <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    take_sample(v, lst);
    @(negedge clk_i);
  endtask

  task automatic send_set(int n, int mode);
    logic [15:0] v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = 16'($urandom);
        1: v = 16'($urandom_range(0, 20)) - 16'd10;
        default: v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      endcase
      send_sample(v, i == n - 1);
    end
  endtask

  // sink with random stalls once enabled, plus a long hold-off on request
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk_i);
        hold_off_cycles = 0;
      end
      gap = sink_stalled ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    sorted_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      last_seen = m_axis_tdata;
      if (sorted_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected item %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = sorted_expect_q.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tlast !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp %h/%b got %h/%b", want.value, want.last,
                     m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic drain;
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (sorted_expect_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    @(negedge clk_i);
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    mismatch_cnt = 0;
    held_sum = '0;
    hold_off_cycles = 0;
    sink_stalled = 1'b0;
    last_seen = '0;
    // single element, extremes
    rows.push_back('{16'h7fff, 1'b1, 1'b1, 16'h7fff});
    rows.push_back('{16'h8000, 1'b1, 1'b1, 16'h8000});
    rows.push_back('{16'h0000, 1'b1, 1'b1, 16'h0000});
    // pair of extremes, equal keys, smaller value first
    rows.push_back('{16'h7fff, 1'b0, 1'b0, '0});
    rows.push_back('{16'h8000, 1'b1, 1'b0, '0});
    // ties and negative truncation
    rows.push_back('{16'd1, 1'b0, 1'b0, '0});
    rows.push_back('{16'hffff, 1'b0, 1'b0, '0});
    rows.push_back('{16'd2, 1'b0, 1'b0, '0});
    rows.push_back('{16'hfffe, 1'b0, 1'b0, '0});
    rows.push_back('{16'd0, 1'b1, 1'b0, '0});
    rows.push_back('{16'd5, 1'b0, 1'b0, '0});
    rows.push_back('{16'd5, 1'b0, 1'b0, '0});
    rows.push_back('{16'd6, 1'b1, 1'b0, '0});
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) begin
      r = rows[i];
      send_sample(r.value, r.last);
      if (r.has_exp) begin
        drain();
        if (last_seen !== r.exp_value) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp %h got %h", r.exp_value, last_seen);
        end
      end
    end
    drain();
    sink_stalled = 1'b1;
    // store full: 66 items, the last two dropped, with the sink held off
    // while the next set is already offered
    hold_off_cycles = 3000;
    send_set(66, 0);
    send_set(8, 2);
    // sender pause until all results are back
    drain();
    for (int s = 0; s < 4; s++) begin
      send_set($urandom_range(1, 8), $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0 && sorted_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
